// ===== hdl/hdstl_pkg.sv =====
// ----------------------------------------------------------------------------
// hdstl_pkg
// Shared types, codes and defaults for the sorted digest table.
// ----------------------------------------------------------------------------
package hdstl_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 32;
  localparam int WORD_W          = 64;
  localparam int KEY_WORDS_MAX   = 4;
  localparam int NAME_W          = 32;
  localparam int COUNT_OUT_W     = 11;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_SHIFT
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    init_search;
    logic    step_search;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    init_shift;
    logic    shift_write;
    logic    ins_write;
    logic    clear_count;
    logic    load_result;
  } cmd_t;

  typedef struct packed {
    op_t  op_in;
    op_t  op_reg;
    logic full;
    logic lo_lt_hi;
    logic ptr_eq_lo;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/hdstl_if.sv =====
// ----------------------------------------------------------------------------
// hdstl_req_if / hdstl_rsp_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface hdstl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [63:0] key_word3;
  logic [31:0] entry_name;

  modport source (
    output valid, opcode, key_word0, key_word1, key_word2, key_word3, entry_name,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_word0, key_word1, key_word2, key_word3, entry_name,
    output ready
  );
endinterface

interface hdstl_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_name;
  logic        status;
  logic [10:0] entry_count;

  modport source (
    output valid, found, match_name, status, entry_count,
    input  ready
  );
  modport sink (
    input  valid, found, match_name, status, entry_count,
    output ready
  );
endinterface

// ===== hdl/hash_digest_sorted_table_lookup_top.sv =====
// Lookup: a binary search over the entries held, each probe a read through the
// registered read port (SEARCH_RD) followed by a compare step (SEARCH_CMP).
// Insert: the same search, then each entry above the slot moved up by a read and
// a write, then the last position check and the write. Clear, unused opcodes and
// dropped inserts go straight to DONE. One item at a time; a finished result
// waits in the output register. Synchronous reset empties the table at once.
// ----------------------------------------------------------------------------
// hash_digest_sorted_table_lookup_top
// Sorted digest table with insert, clear and binary-search lookup.
// ----------------------------------------------------------------------------
module hash_digest_sorted_table_lookup_top import hdstl_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  hdstl_req_if.sink   req,
  hdstl_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  hdstl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hdstl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (req.opcode),
    .key_word0   (req.key_word0),
    .key_word1   (req.key_word1),
    .key_word2   (req.key_word2),
    .key_word3   (req.key_word3),
    .entry_name  (req.entry_name),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .found       (rsp.found),
    .match_name  (rsp.match_name),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

endmodule

// ===== hdl/hdstl_dp.sv =====
// ----------------------------------------------------------------------------
// hdstl_dp
// Datapath: key/name memories, search bounds, shift pointer, entry count
// and the result register.
// ----------------------------------------------------------------------------
module hdstl_dp import hdstl_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             opcode,
  input  logic [WORD_W-1:0]      key_word0,
  input  logic [WORD_W-1:0]      key_word1,
  input  logic [WORD_W-1:0]      key_word2,
  input  logic [WORD_W-1:0]      key_word3,
  input  logic [NAME_W-1:0]      entry_name,
  input  logic                   rsp_ready,
  output logic                   rsp_valid,
  output logic                   found,
  output logic [NAME_W-1:0]      match_name,
  output logic                   status,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = KEY_BYTES * 8;
  localparam int FULLW = KEY_WORDS_MAX * WORD_W;

  logic [KW-1:0]     key_mem  [TABLE_DEPTH];
  logic [NAME_W-1:0] name_mem [TABLE_DEPTH];

  logic [FULLW-1:0]  key_full;
  logic [KW-1:0]     probe_in;

  op_t               op;
  logic [KW-1:0]     probe;
  logic [NAME_W-1:0] name_in;
  logic              dropped;
  logic [CW-1:0]     count;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     ptr;
  logic [KW-1:0]     rd_key;
  logic [NAME_W-1:0] rd_name;

  logic [CW-1:0]     mid;
  logic [CW-1:0]     ptr_dec;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [KW-1:0]     wr_key;
  logic [NAME_W-1:0] wr_name;
  logic              key_lt;
  logic              key_eq;
  logic              go_right;
  logic              hit;
  logic              full;
  logic [COUNT_OUT_W+CW-1:0] count_ext;

  // Byte 0 is the top byte, so the key order is plain unsigned order of the
  // concatenation; bytes past KEY_BYTES are dropped.
  assign key_full = {key_word0, key_word1, key_word2, key_word3};
  assign probe_in = key_full[FULLW-1 -: KW];

  assign mid     = lo + ((hi - lo) >> 1);
  assign ptr_dec = ptr - 1'b1;
  assign full    = (count >= CW'(TABLE_DEPTH));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:   rd_addr = mid[AW-1:0];
      RD_LO:    rd_addr = lo[AW-1:0];
      RD_SHIFT: rd_addr = ptr_dec[AW-1:0];
      default:  rd_addr = lo[AW-1:0];
    endcase
  end

  assign we      = cmd.shift_write | cmd.ins_write;
  assign wr_addr = cmd.shift_write ? ptr[AW-1:0] : lo[AW-1:0];
  assign wr_key  = cmd.shift_write ? rd_key : probe;
  assign wr_name = cmd.shift_write ? rd_name : name_in;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr]  <= wr_key;
      name_mem[wr_addr] <= wr_name;
    end
    if (cmd.rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_name <= name_mem[rd_addr];
    end
  end

  assign key_lt   = (rd_key < probe);
  assign key_eq   = (rd_key == probe);
  // Inserts look for the first entry above the key, lookups the first not below.
  assign go_right = key_lt || ((op == OP_INSERT) && key_eq);
  assign hit      = (op == OP_LOOKUP) && (lo < count) && key_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.ins_write) begin
        count <= count + 1'b1;
      end
      if (cmd.load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= op_t'(opcode);
      probe   <= probe_in;
      name_in <= entry_name;
      dropped <= (op_t'(opcode) == OP_INSERT) && full;
    end
    if (cmd.init_search) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.step_search) begin
      if (go_right) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.init_shift) begin
      ptr <= count;
    end else if (cmd.shift_write) begin
      ptr <= ptr_dec;
    end
    if (cmd.load_result) begin
      found       <= hit;
      match_name  <= hit ? rd_name : '0;
      status      <= dropped;
      entry_count <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign sts.op_in     = op_t'(opcode);
  assign sts.op_reg    = op;
  assign sts.full      = full;
  assign sts.lo_lt_hi  = (lo < hi);
  assign sts.ptr_eq_lo = (ptr == lo);
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

// ===== hdl/hdstl_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdstl_ctrl
// Controller: sequences search probes, the insert shift and result loading.
// ----------------------------------------------------------------------------
module hdstl_ctrl import hdstl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (sts.op_in)
            OP_INSERT: state_next = sts.full ? ST_DONE : ST_SEARCH_RD;
            OP_LOOKUP: state_next = ST_SEARCH_RD;
            OP_CLEAR:  state_next = ST_DONE;
            OP_NOP:    state_next = ST_DONE;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_SEARCH_RD: begin
        if (sts.lo_lt_hi) begin
          state_next = ST_SEARCH_CMP;
        end else if (sts.op_reg == OP_LOOKUP) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SEARCH_CMP: state_next = ST_SEARCH_RD;
      ST_SHIFT_RD:   state_next = sts.ptr_eq_lo ? ST_INS_WR : ST_SHIFT_WR;
      ST_SHIFT_WR:   state_next = ST_SHIFT_RD;
      ST_INS_WR:     state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = cmd_t'('0);
    cmd.rd_sel = RD_MID;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept      = 1'b1;
          cmd.init_search = 1'b1;
          cmd.clear_count = (sts.op_in == OP_CLEAR);
        end
      end
      ST_SEARCH_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
        end else if (sts.op_reg == OP_LOOKUP) begin
          // final read at the lower bound, checked for equality in DONE
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LO;
        end else begin
          cmd.init_shift = 1'b1;
        end
      end
      ST_SEARCH_CMP: cmd.step_search = 1'b1;
      ST_SHIFT_RD: begin
        if (!sts.ptr_eq_lo) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SHIFT;
        end
      end
      ST_SHIFT_WR: cmd.shift_write = 1'b1;
      ST_INS_WR:   cmd.ins_write   = 1'b1;
      ST_DONE:     cmd.load_result = sts.out_free;
      default:     cmd.load_result = 1'b0;
    endcase
  end

endmodule

// ===== tb/sv/hdstl_table_checker.sv =====
// ----------------------------------------------------------------------------
// hdstl_table_checker
// Watches the request and result channels, keeps a shadow of the sorted
// digest table, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module hdstl_table_checker import hdstl_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  hdstl_req_if        req,
  hdstl_rsp_if        rsp,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned hit_count,
  output int unsigned drop_count
);

  localparam int KEY_W = KEY_WORDS_MAX * WORD_W;
  // key bytes past KEY_BYTES never take part in order or matching
  localparam logic [KEY_W-1:0] KEY_MASK =
    {KEY_W{1'b1}} << (8 * (KEY_WORDS_MAX * 8 - KEY_BYTES));

  typedef struct packed {
    logic                   found;
    logic [NAME_W-1:0]      match_name;
    logic                   status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } table_result_t;

  logic [KEY_W-1:0]  key_tab  [TABLE_DEPTH];
  logic [NAME_W-1:0] name_tab [TABLE_DEPTH];
  int unsigned       entries;
  table_result_t     result_q [$];

  // First position whose key is above the probe (upper) or not below it.
  function automatic int unsigned key_bound(input logic [KEY_W-1:0] probe, input bit upper);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_tab[mid] < probe || (upper && key_tab[mid] == probe)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic apply_request(input op_t op, input logic [KEY_W-1:0] raw_key,
                               input logic [NAME_W-1:0] name, output table_result_t res);
    logic [KEY_W-1:0] probe;
    int unsigned      pos;
    int unsigned      i;
    probe = raw_key & KEY_MASK;
    res   = '0;
    case (op)
      OP_CLEAR: begin
        entries = 0;
      end
      OP_INSERT: begin
        if (entries >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          // new entry lands after every equal key
          pos = key_bound(probe, 1'b1);
          for (i = entries; i > pos; i--) begin
            key_tab[i]  = key_tab[i-1];
            name_tab[i] = name_tab[i-1];
          end
          key_tab[pos]  = probe;
          name_tab[pos] = name;
          entries++;
        end
      end
      OP_LOOKUP: begin
        pos = key_bound(probe, 1'b0);
        if (pos < entries && key_tab[pos] == probe) begin
          res.found      = 1'b1;
          res.match_name = name_tab[pos];
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_OUT_W'(entries);
  endtask

  task automatic check_field(input string field, input logic [NAME_W-1:0] want,
                             input logic [NAME_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    table_result_t want;
    table_result_t got;
    if (rst) begin
      entries = 0;
      result_q.delete();
      pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.found       = rsp.found;
        got.match_name  = rsp.match_name;
        got.status      = rsp.status;
        got.entry_count = rsp.entry_count;
        if (result_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("found", want.found, got.found);
          check_field("match_name", want.match_name, got.match_name);
          check_field("status", want.status, got.status);
          check_field("entry_count", want.entry_count, got.entry_count);
        end
      end
      if (req.valid && req.ready) begin
        apply_request(op_t'(req.opcode),
                      {req.key_word0, req.key_word1, req.key_word2, req.key_word3},
                      req.entry_name, want);
        result_q.push_back(want);
        if (want.found) hit_count++;
        if (want.status) drop_count++;
      end
      pending <= result_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted digest table: directed corner cases, random
// insert/lookup/clear traffic under several idling mixes, and a pass that
// fills the table to its limit. Checking is done by hdstl_table_checker.
// ----------------------------------------------------------------------------
module tb;
  import hdstl_pkg::*;

  localparam int TABLE_DEPTH    = DEF_TABLE_DEPTH;
  localparam int KEY_BYTES      = DEF_KEY_BYTES;
  localparam int KEY_W          = KEY_WORDS_MAX * WORD_W;
  localparam int RANDOM_ITEMS   = 200;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int FILL_ASCENDING = TABLE_DEPTH - 4;
  localparam int SETTLE_CYCLES  = 50;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        rsp_ready = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_token   = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned sent_count   = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned hit_count;
  int unsigned drop_count;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [KEY_W-1:0] filled_keys [$];

  hdstl_req_if req ();
  hdstl_rsp_if rsp ();

  assign rsp.ready = rsp_ready;

  hash_digest_sorted_table_lookup_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  hdstl_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) u_table_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending),
    .hit_count (hit_count),
    .drop_count(drop_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off each time hold_token moves.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] key;
    int unsigned      i;
    for (i = 0; i < KEY_W / 32; i++) key[i*32 +: 32] = $urandom;
    return key;
  endfunction

  function automatic logic [NAME_W-1:0] rand_name();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return $urandom;
  endfunction

  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [NAME_W-1:0] name);
    while ($urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.key_word0  <= key[KEY_W-1 -: WORD_W];
    req.key_word1  <= key[KEY_W-WORD_W-1 -: WORD_W];
    req.key_word2  <= key[KEY_W-2*WORD_W-1 -: WORD_W];
    req.key_word3  <= key[WORD_W-1:0];
    req.entry_name <= name;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_count++;
  endtask

  // Sender goes quiet until every outstanding result has been taken.
  task automatic wait_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly pool keys so lookups hit, some one-bit neighbors, some fresh keys.
  task automatic send_random_request();
    op_t              op;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 4) op = OP_CLEAR;
    else if (pick < 7) op = OP_NOP;
    else if (pick < 52) op = OP_INSERT;
    else op = OP_LOOKUP;
    key  = key_pool[$urandom_range(POOL_SIZE-1)];
    pick = $urandom_range(99);
    if (pick < 20) key[$urandom_range(KEY_W-1)] ^= 1'b1;
    else if (pick < 35) key = rand_key();
    send_request(op, key, rand_name());
  endtask

  initial begin
    logic [KEY_W-1:0] mid_key;
    logic [KEY_W-1:0] alt_key;
    logic [KEY_W-1:0] key;
    int unsigned      phase;
    int unsigned      i;

    req.valid      <= 1'b0;
    req.opcode     <= OP_CLEAR;
    req.key_word0  <= '0;
    req.key_word1  <= '0;
    req.key_word2  <= '0;
    req.key_word3  <= '0;
    req.entry_name <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners: empty table, extremes, duplicates, near misses
    mid_key = rand_key();
    alt_key = {KEY_W/WORD_W{64'hAAAA_AAAA_5555_5555}};
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_NOP, '1, '1);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, mid_key, 1);
    send_request(OP_INSERT, mid_key, 2);
    send_request(OP_INSERT, mid_key, 3);
    send_request(OP_LOOKUP, mid_key, '0);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_INSERT, mid_key ^ KEY_W'(1), 4);
    send_request(OP_INSERT, mid_key ^ {1'b1, {KEY_W-1{1'b0}}}, 5);
    send_request(OP_LOOKUP, mid_key ^ KEY_W'(1), '0);
    send_request(OP_LOOKUP, mid_key ^ KEY_W'(2), '0);
    send_request(OP_LOOKUP, mid_key ^ {1'b1, {KEY_W-1{1'b0}}}, '0);
    send_request(OP_NOP, mid_key, 7);
    send_request(OP_CLEAR, mid_key, '1);
    send_request(OP_LOOKUP, mid_key, '0);
    send_request(OP_INSERT, alt_key, 32'h5555_AAAA);
    send_request(OP_LOOKUP, alt_key, '0);
    send_request(OP_LOOKUP, ~alt_key, '0);
    send_request(OP_CLEAR, '1, '1);
    wait_results();

    // random traffic: no random idling, sender gaps, receiver stalls, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct <= 0;  end
        1: begin send_gap_pct = 69; stall_pct <= 0;  end
        2: begin send_gap_pct = 0;  stall_pct <= 69; end
        default: begin send_gap_pct = 21; stall_pct <= 21; end
      endcase
      // odd pool entries share all but the last word with their neighbor
      for (i = 0; i < POOL_SIZE; i++) begin
        key_pool[i] = rand_key();
        if (i % 2 == 1) key_pool[i][KEY_W-1:WORD_W] = key_pool[i-1][KEY_W-1:WORD_W];
      end
      if (phase == 0 || phase == 3) hold_token <= hold_token + 1;
      for (i = 0; i < RANDOM_ITEMS / 4; i++) send_random_request();
      wait_results();
    end

    // fill to the limit with ascending keys, then a few shifted inserts
    send_gap_pct = 0;
    stall_pct <= 0;
    send_request(OP_CLEAR, rand_key(), rand_name());
    for (i = 0; i < FILL_ASCENDING; i++) begin
      key = rand_key();
      key[KEY_W-1 -: 16] = 16'(i);
      filled_keys.push_back(key);
      send_request(OP_INSERT, key, rand_name());
      if (i % 16 == 15) send_request(OP_LOOKUP, filled_keys[$urandom_range(i)], rand_name());
    end
    send_request(OP_INSERT, '0, rand_name());
    for (i = FILL_ASCENDING + 1; i < TABLE_DEPTH; i++)
      send_request(OP_INSERT, rand_key(), rand_name());
    // table is full now: these must be turned away
    send_request(OP_INSERT, rand_key(), rand_name());
    send_request(OP_INSERT, filled_keys[0], rand_name());
    send_request(OP_INSERT, '1, '1);
    send_gap_pct = 21;
    stall_pct <= 21;
    for (i = 0; i < 16; i++)
      send_request(OP_LOOKUP, filled_keys[$urandom_range(FILL_ASCENDING-1)], rand_name());
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, rand_key(), rand_name());
    send_request(OP_NOP, rand_key(), rand_name());
    send_request(OP_CLEAR, rand_key(), rand_name());
    send_request(OP_LOOKUP, filled_keys[0], rand_name());

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests: directed corners, four idling mixes, a full-table pass.",
             sent_count);
    $display("%0d lookups found their key, %0d inserts dropped on a full table.",
             hit_count, drop_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
